@@ hdl/dat_pkg.sv @@
// shared types and constants for the daily aggregate table
package dat_pkg;

    // default number of slots in the table
    localparam int SLOTS_DEF = 32;

    // sample count ceiling
    localparam logic [15:0] SAMPLE_MAX = 16'hFFFF;

    // operation codes
    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_GET   = 3'd1;
    localparam logic [2:0] OP_PURGE = 3'd2;
    localparam logic [2:0] OP_READ  = 3'd3;
    localparam logic [2:0] OP_WIPE  = 3'd4;

    // input word
    typedef struct packed {
        logic [2:0]         operation;
        logic [31:0]        day_stamp;
        logic [15:0]        drink_vol;
        logic [15:0]        purity_val;
        logic signed [15:0] temp_tenths;
        logic [4:0]         slot_index;
    } t_in_word;

    // result word
    typedef struct packed {
        logic               ok;
        logic               rec_valid;
        logic [31:0]        rec_day;
        logic [31:0]        rec_total_ml;
        logic [31:0]        rec_purity_sum;
        logic signed [31:0] rec_temp_sum;
        logic [15:0]        rec_samples;
        logic [5:0]         used_count;
    } t_out_word;

    // one slot as held in the memory
    typedef struct packed {
        logic               valid;
        logic [31:0]        day;
        logic [31:0]        total;
        logic [31:0]        purity;
        logic signed [31:0] temp;
        logic [15:0]        samples;
    } t_slot;

endpackage

@@ hdl/daily_aggregate_table_unit.sv @@
// daily aggregate table: slot memory, scan sequencer and result register
//
//  channel | valid      | stall       | word
//  --------+------------+-------------+------------
//  input   | i_in_valid | o_in_stall  | i_in_word
//  result  | o_out_valid| i_out_stall | o_out_word
//
// after reset a clearing pass writes every slot to zero; no word is taken meanwhile.
// add, get and purge walk the slot memory one read per cycle through its single
// read port; add and get end the walk early on a match, purge walks every slot.
// an in-range read goes via ST_RD to ST_DONE; wipe and undefined operations do not.
// one word is worked on at a time; the result register lets the next word in while
// a result still waits under i_out_stall.
module daily_aggregate_table_unit #(
    parameter int SLOTS = dat_pkg::SLOTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  dat_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output dat_pkg::t_out_word o_out_word
);
    import dat_pkg::*;

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [AW-1:0] ADDR_LAST = AW'(SLOTS - 1);
    localparam logic [CW-1:0] CNT_MAX   = CW'(SLOTS);

    // sequencer states
    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_RD   = 3'd2;
    localparam logic [2:0] ST_SCAN = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_addr, n_addr;
    logic          r_pend, n_pend;
    logic [AW-1:0] r_chk_addr, n_chk_addr;
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_claimed, n_claimed;
    t_in_word      r_in, n_in;
    t_out_word     r_res, n_res;
    t_out_word     r_out, n_out;
    logic          r_out_valid, n_out_valid;

    // slot memory
    t_slot         r_mem [SLOTS];
    t_slot         r_q;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_wa, mem_ra;
    t_slot         mem_wd;

    // derived values
    logic          hit, older, last;
    t_slot         upd, claim, aged;
    logic [CW-1:0] claimed_inc;
    logic [AW-1:0] head_nxt;
    logic [CW+5:0] cnt_ext, inc_ext;
    logic [5:0]    used_cur, used_inc;
    logic [AW+4:0] idx_ext;
    logic          idx_in_range;

    // slot to result word
    function automatic t_out_word rec_of(input t_slot s, input logic [5:0] used);
        t_out_word w;
        w.ok             = 1'b1;
        w.rec_valid      = s.valid;
        w.rec_day        = s.day;
        w.rec_total_ml   = s.total;
        w.rec_purity_sum = s.purity;
        w.rec_temp_sum   = s.temp;
        w.rec_samples    = s.samples;
        w.used_count     = used;
        return w;
    endfunction

    // empty result word
    function automatic t_out_word blank_of(input logic ok, input logic [5:0] used);
        t_out_word w;
        w            = '0;
        w.ok         = ok;
        w.used_count = used;
        return w;
    endfunction

    // match tests and updated records
    always_comb begin
        hit   = r_q.valid && (r_q.day == r_in.day_stamp);
        older = r_q.valid && (r_q.day < r_in.day_stamp);
        last  = (r_chk_addr == ADDR_LAST);

        upd         = r_q;
        upd.total   = r_q.total + {16'b0, r_in.drink_vol};
        upd.purity  = r_q.purity + {16'b0, r_in.purity_val};
        upd.temp    = r_q.temp + {{16{r_in.temp_tenths[15]}}, r_in.temp_tenths};
        upd.samples = (r_q.samples != SAMPLE_MAX) ? r_q.samples + 16'd1 : r_q.samples;

        claim.valid   = 1'b1;
        claim.day     = r_in.day_stamp;
        claim.total   = {16'b0, r_in.drink_vol};
        claim.purity  = {16'b0, r_in.purity_val};
        claim.temp    = {{16{r_in.temp_tenths[15]}}, r_in.temp_tenths};
        claim.samples = 16'd1;

        aged       = r_q;
        aged.valid = 1'b0;

        claimed_inc = (r_claimed == CNT_MAX) ? r_claimed : r_claimed + CW'(1);
        head_nxt    = (r_head == ADDR_LAST) ? '0 : r_head + AW'(1);

        cnt_ext  = (CW + 6)'(r_claimed);
        inc_ext  = (CW + 6)'(claimed_inc);
        used_cur = cnt_ext[5:0];
        used_inc = inc_ext[5:0];

        idx_ext      = (AW + 5)'(i_in_word.slot_index);
        idx_in_range = ({27'b0, i_in_word.slot_index} < 32'(SLOTS));
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_pend      = 1'b0;
        n_chk_addr  = r_chk_addr;
        n_head      = r_head;
        n_claimed   = r_claimed;
        n_in        = r_in;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        mem_we      = 1'b0;
        mem_wa      = '0;
        mem_wd      = '0;
        mem_re      = 1'b0;
        mem_ra      = '0;

        // result register drains
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_CLR: begin
                mem_we = 1'b1;
                mem_wa = r_addr[AW-1:0];
                if (r_addr[AW-1:0] == ADDR_LAST) begin
                    n_addr  = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_addr = r_addr + CW'(1);
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_in   = i_in_word;
                    n_addr = '0;
                    case (i_in_word.operation)
                        OP_ADD, OP_GET, OP_PURGE: begin
                            n_state = ST_SCAN;
                        end
                        OP_READ: begin
                            if (idx_in_range) begin
                                mem_re  = 1'b1;
                                mem_ra  = idx_ext[AW-1:0];
                                n_state = ST_RD;
                            end else begin
                                n_res   = blank_of(1'b0, used_cur);
                                n_state = ST_DONE;
                            end
                        end
                        OP_WIPE: begin
                            n_head    = '0;
                            n_claimed = '0;
                            n_res     = blank_of(1'b1, 6'd0);
                            n_state   = ST_DONE;
                        end
                        default: begin
                            n_res   = blank_of(1'b0, used_cur);
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_RD: begin
                n_res   = rec_of(r_q, used_cur);
                n_state = ST_DONE;
            end
            ST_SCAN: begin
                // issue the next slot read
                if (r_addr != CNT_MAX) begin
                    mem_re     = 1'b1;
                    mem_ra     = r_addr[AW-1:0];
                    n_addr     = r_addr + CW'(1);
                    n_pend     = 1'b1;
                    n_chk_addr = r_addr[AW-1:0];
                end
                // look at the slot read last cycle
                if (r_pend) begin
                    case (r_in.operation)
                        OP_ADD: begin
                            if (hit) begin
                                mem_we  = 1'b1;
                                mem_wa  = r_chk_addr;
                                mem_wd  = upd;
                                n_res   = rec_of(upd, used_cur);
                                n_state = ST_DONE;
                            end else if (last) begin
                                mem_we    = 1'b1;
                                mem_wa    = r_head;
                                mem_wd    = claim;
                                n_head    = head_nxt;
                                n_claimed = claimed_inc;
                                n_res     = rec_of(claim, used_inc);
                                n_state   = ST_DONE;
                            end
                        end
                        OP_GET: begin
                            if (hit) begin
                                n_res   = rec_of(r_q, used_cur);
                                n_state = ST_DONE;
                            end else if (last) begin
                                n_res   = blank_of(1'b0, used_cur);
                                n_state = ST_DONE;
                            end
                        end
                        OP_PURGE: begin
                            if (older) begin
                                mem_we = 1'b1;
                                mem_wa = r_chk_addr;
                                mem_wd = aged;
                            end
                            if (last) begin
                                n_res   = blank_of(1'b1, used_cur);
                                n_state = ST_DONE;
                            end
                        end
                        default: begin
                            n_res   = blank_of(1'b0, used_cur);
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_addr      <= '0;
            r_pend      <= 1'b0;
            r_chk_addr  <= '0;
            r_head      <= '0;
            r_claimed   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_pend      <= n_pend;
            r_chk_addr  <= n_chk_addr;
            r_head      <= n_head;
            r_claimed   <= n_claimed;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_in  <= n_in;
        r_res <= n_res;
        r_out <= n_out;
    end

    // slot memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_q <= r_mem[mem_ra];
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // ring head stays inside the table
    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= ADDR_LAST)
        else $error("ring head beyond last slot");

    // claimed count never passes the slot count
    a_claimed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_claimed <= CNT_MAX)
        else $error("claimed count beyond slot count");

    // memory is written only by the clearing pass or a scan
    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == ST_CLR || r_state == ST_SCAN))
        else $error("slot write outside clear or scan");

    // no result appears during the clearing pass
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLR) |-> !r_out_valid)
        else $error("result during clearing pass");

    // a scan looks only at slots it has read
    a_scan_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && r_pend) |-> (r_addr != '0))
        else $error("slot checked before its read");

endmodule
